// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds define SYNTH and
// get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BSP_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define BSP_ASSERT_NEVER(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define BSP_ASSERT(name, clk, rstn, prop)
`define BSP_ASSERT_NEVER(name, clk, rstn, cond)
`endif
`endif

// File: rtl/bsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box support point package
// Word types, register indexes, datapath commands and shared arithmetic
// helpers for the box support point block.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;

    // Configuration register indexes.
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_BOX_MIN_X = 3'd0;
    localparam cfg_idx_t CFG_BOX_MIN_Y = 3'd1;
    localparam cfg_idx_t CFG_BOX_MIN_Z = 3'd2;
    localparam cfg_idx_t CFG_BOX_MAX_X = 3'd3;
    localparam cfg_idx_t CFG_BOX_MAX_Y = 3'd4;
    localparam cfg_idx_t CFG_BOX_MAX_Z = 3'd5;

    localparam logic signed [63:0] QONE64 = 64'sd1073741824;
    localparam logic signed [31:0] QONE32 = 32'sd1073741824;
    localparam logic signed [63:0] ONE60  = 64'sd1152921504606846976;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] bias_amount;
    } bsp_in_t;

    typedef struct packed {
        logic signed [31:0] support_x;
        logic signed [31:0] support_y;
        logic signed [31:0] support_z;
    } bsp_out_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_QMUL, OP_MAT, OP_RMUL, OP_CPT, OP_DMUL, OP_DCMP,
        OP_SQ, OP_LSUM, OP_NORM, OP_SQINIT, OP_SQSTEP, OP_DVINIT, OP_DVSTEP,
        OP_BMUL, OP_BADD, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] idx;
    } bsp_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic norm_done;
    } bsp_stat_t;

    // Saturate a 64-bit value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return $signed(v[31:0]);
        end
    endfunction

    // Clamp a quaternion component to [-1.0, 1.0] in Q2.30.
    function automatic logic signed [31:0] clamp_q(input logic signed [31:0] v);
        if (v > QONE32) begin
            return QONE32;
        end else if (v < -QONE32) begin
            return -QONE32;
        end else begin
            return v;
        end
    endfunction

    // Rotation matrix entry: Q.60 down to Q.30, clamped to [-1.0, 1.0].
    function automatic logic signed [31:0] mat_entry(input logic signed [63:0] q60);
        logic signed [63:0] t;
        t = q60 >>> 30;
        if (t > QONE64) begin
            return QONE32;
        end else if (t < -QONE64) begin
            return -QONE32;
        end else begin
            return $signed(t[31:0]);
        end
    endfunction

    // Corner visiting order: bit i set means axis i takes the maximum.
    function automatic logic [2:0] corner_sel(input logic [2:0] c);
        case (c)
            3'd0:    return 3'd0;
            3'd1:    return 3'd1;
            3'd2:    return 3'd2;
            3'd3:    return 3'd4;
            3'd4:    return 3'd7;
            3'd5:    return 3'd6;
            3'd6:    return 3'd5;
            3'd7:    return 3'd3;
            default: return 3'd0;
        endcase
    endfunction

endpackage

// File: rtl/bsp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box support point controller
// Sequences one word at a time through the datapath and owns the input and
// result handshakes.
// ----------------------------------------------------------------------------
module bsp_ctrl import bsp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  bsp_stat_t stat,
    output bsp_cmd_t  cmd
);

    typedef enum logic [16:0] {
        ST_IDLE   = 17'b00000000000000001,
        ST_QMUL   = 17'b00000000000000010,
        ST_MAT    = 17'b00000000000000100,
        ST_RMUL   = 17'b00000000000001000,
        ST_CPT    = 17'b00000000000010000,
        ST_DMUL   = 17'b00000000000100000,
        ST_DCMP   = 17'b00000000001000000,
        ST_SQ     = 17'b00000000010000000,
        ST_LSUM   = 17'b00000000100000000,
        ST_NORM   = 17'b00000001000000000,
        ST_SQINIT = 17'b00000010000000000,
        ST_SQSTEP = 17'b00000100000000000,
        ST_DVINIT = 17'b00001000000000000,
        ST_DVSTEP = 17'b00010000000000000,
        ST_BMUL   = 17'b00100000000000000,
        ST_BADD   = 17'b01000000000000000,
        ST_FIN    = 17'b10000000000000000
    } state_t;

    localparam logic [4:0] QMUL_LAST   = 5'd2;
    localparam logic [4:0] RMUL_LAST   = 5'd5;
    localparam logic [4:0] CORNER_LAST = 5'd7;
    localparam logic [4:0] ITER_LAST   = 5'd31;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;

    assign m_valid = m_valid_reg;

    // Next state, step counter and command decode.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.op       = OP_NOP;
        cmd.idx      = cnt_reg;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    cnt_next   = '0;
                    state_next = ST_QMUL;
                end
            end
            ST_QMUL: begin
                cmd.op = OP_QMUL;
                if (cnt_reg == QMUL_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_MAT;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_MAT: begin
                cmd.op     = OP_MAT;
                cnt_next   = '0;
                state_next = ST_RMUL;
            end
            ST_RMUL: begin
                cmd.op = OP_RMUL;
                if (cnt_reg == RMUL_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_CPT;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_CPT: begin
                cmd.op     = OP_CPT;
                state_next = ST_DMUL;
            end
            ST_DMUL: begin
                cmd.op     = OP_DMUL;
                state_next = ST_DCMP;
            end
            ST_DCMP: begin
                cmd.op = OP_DCMP;
                if (cnt_reg == CORNER_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end else begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = ST_CPT;
                end
            end
            ST_SQ: begin
                cmd.op     = OP_SQ;
                state_next = ST_LSUM;
            end
            ST_LSUM: begin
                cmd.op     = OP_LSUM;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if (stat.len_zero) begin
                    state_next = ST_FIN;
                end else if (stat.norm_done) begin
                    state_next = ST_SQINIT;
                end else begin
                    cmd.op = OP_NORM;
                end
            end
            ST_SQINIT: begin
                cmd.op     = OP_SQINIT;
                cnt_next   = '0;
                state_next = ST_SQSTEP;
            end
            ST_SQSTEP: begin
                cmd.op = OP_SQSTEP;
                if (cnt_reg == ITER_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_DVINIT;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DVINIT: begin
                cmd.op     = OP_DVINIT;
                cnt_next   = '0;
                state_next = ST_DVSTEP;
            end
            ST_DVSTEP: begin
                cmd.op = OP_DVSTEP;
                if (cnt_reg == ITER_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_BMUL;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_BMUL: begin
                cmd.op     = OP_BMUL;
                state_next = ST_BADD;
            end
            ST_BADD: begin
                cmd.op     = OP_BADD;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // Hand over to the output register once it is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/bsp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box support point datapath
// Configuration registers, three multiplier lanes, corner search, integer
// square root and three radix-2 dividers, driven by controller commands.
// ----------------------------------------------------------------------------
module bsp_datapath import bsp_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr,
    input  cfg_idx_t    cfg_index,
    input  logic [31:0] cfg_data,
    input  bsp_in_t     in_data,
    input  bsp_cmd_t    cmd,
    output bsp_stat_t   stat,
    output bsp_out_t    out_data
);

    // Box corners.
    logic signed [31:0] mn_reg [3];
    logic signed [31:0] mx_reg [3];

    // Captured word.
    logic signed [31:0] d_reg [3];
    logic signed [31:0] p_reg [3];
    logic signed [31:0] qw_reg, qx_reg, qy_reg, qz_reg, bias_reg;

    // Working registers.
    logic signed [63:0] qp_reg [9];
    logic signed [31:0] r_reg  [3][3];
    logic signed [63:0] rv_reg [3][3][2];
    logic signed [31:0] pt_reg [3];
    logic signed [31:0] best_reg [3];
    logic signed [63:0] dp_reg [3];
    logic signed [63:0] best_dot_reg;
    logic [63:0]        len2_reg;
    logic [4:0]         k_reg;
    logic [63:0]        sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [31:0]        dv_rem_reg [3];
    logic [31:0]        dv_num_reg [3];
    logic [31:0]        dv_q_reg   [3];
    bsp_out_t           out_reg;

    // Combinational results.
    logic signed [31:0] mul_a [3];
    logic signed [31:0] mul_b [3];
    logic signed [63:0] mul_p [3];
    logic signed [31:0] r_next [3][3];
    logic [2:0]         csel;
    logic signed [63:0] acc [3];
    logic signed [31:0] pt_next [3];
    logic signed [63:0] dot_next;
    logic [63:0]        sq_try;
    logic               sq_take;
    logic [31:0]        lroot;
    logic [31:0]        mag [3];
    logic [63:0]        num_init [3];
    logic [32:0]        dv_sh [3];
    logic               dv_take [3];
    logic signed [31:0] nq [3];
    logic signed [31:0] badd_next [3];
    logic [1:0]         rcol;

    assign out_data       = out_reg;
    assign stat.len_zero  = (len2_reg == 64'd0);
    assign stat.norm_done = |len2_reg[63:62];
    assign lroot          = sq_res_reg[31:0];
    assign rcol           = cmd.idx[2:1];
    assign csel           = corner_sel(cmd.idx[2:0]);

    // Multiplier lane operand selection.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mul_a[i] = '0;
            mul_b[i] = '0;
            case (cmd.op)
                OP_QMUL: begin
                    case (cmd.idx[1:0])
                        2'd0: begin
                            mul_a[i] = (i == 0) ? qy_reg : ((i == 1) ? qz_reg : qx_reg);
                            mul_b[i] = mul_a[i];
                        end
                        2'd1: begin
                            mul_a[i] = (i == 1) ? qw_reg : qx_reg;
                            mul_b[i] = (i == 0) ? qy_reg : qz_reg;
                        end
                        2'd2: begin
                            mul_a[i] = (i == 1) ? qy_reg : qw_reg;
                            mul_b[i] = (i == 0) ? qy_reg : ((i == 1) ? qz_reg : qx_reg);
                        end
                        default: begin
                            mul_a[i] = '0;
                        end
                    endcase
                end
                OP_RMUL: begin
                    case (rcol)
                        2'd0: begin
                            mul_a[i] = r_reg[i][0];
                            mul_b[i] = cmd.idx[0] ? mx_reg[0] : mn_reg[0];
                        end
                        2'd1: begin
                            mul_a[i] = r_reg[i][1];
                            mul_b[i] = cmd.idx[0] ? mx_reg[1] : mn_reg[1];
                        end
                        2'd2: begin
                            mul_a[i] = r_reg[i][2];
                            mul_b[i] = cmd.idx[0] ? mx_reg[2] : mn_reg[2];
                        end
                        default: begin
                            mul_a[i] = '0;
                        end
                    endcase
                end
                OP_DMUL: begin
                    mul_a[i] = pt_reg[i];
                    mul_b[i] = d_reg[i];
                end
                OP_SQ: begin
                    mul_a[i] = d_reg[i];
                    mul_b[i] = d_reg[i];
                end
                OP_BMUL: begin
                    mul_a[i] = nq[i];
                    mul_b[i] = bias_reg;
                end
                default: begin
                    mul_a[i] = '0;
                end
            endcase
            mul_p[i] = mul_a[i] * mul_b[i];
        end
    end

    // Rotation matrix from the quaternion products.
    always_comb begin
        r_next[0][0] = mat_entry(ONE60 - ((qp_reg[0] + qp_reg[1]) <<< 1));
        r_next[0][1] = mat_entry((qp_reg[3] - qp_reg[4]) <<< 1);
        r_next[0][2] = mat_entry((qp_reg[5] + qp_reg[6]) <<< 1);
        r_next[1][0] = mat_entry((qp_reg[3] + qp_reg[4]) <<< 1);
        r_next[1][1] = mat_entry(ONE60 - ((qp_reg[2] + qp_reg[1]) <<< 1));
        r_next[1][2] = mat_entry((qp_reg[7] - qp_reg[8]) <<< 1);
        r_next[2][0] = mat_entry((qp_reg[5] - qp_reg[6]) <<< 1);
        r_next[2][1] = mat_entry((qp_reg[7] + qp_reg[8]) <<< 1);
        r_next[2][2] = mat_entry(ONE60 - ((qp_reg[2] + qp_reg[0]) <<< 1));
    end

    // Corner point, dot product, divider steps and bias terms per lane.
    always_comb begin
        dot_next = '0;
        for (int i = 0; i < 3; i++) begin
            acc[i] = rv_reg[i][0][csel[0]] + rv_reg[i][1][csel[1]]
                   + rv_reg[i][2][csel[2]];
            pt_next[i] = sat32((acc[i] >>> 30) + $signed({{32{p_reg[i][31]}}, p_reg[i]}));
            dot_next = dot_next + (dp_reg[i] >>> COORD_FRAC_BITS);

            mag[i] = d_reg[i][31] ? 32'($unsigned(-d_reg[i])) : 32'($unsigned(d_reg[i]));
            num_init[i] = ({32'd0, mag[i]} << k_reg) << 30;

            dv_sh[i]   = {dv_rem_reg[i], dv_num_reg[i][31]};
            dv_take[i] = (dv_sh[i] >= {1'b0, lroot});

            nq[i] = d_reg[i][31] ? -$signed(dv_q_reg[i]) : $signed(dv_q_reg[i]);
            badd_next[i] = sat32($signed({{32{best_reg[i][31]}}, best_reg[i]})
                                 + (dp_reg[i] >>> 30));
        end
    end

    // Square root trial subtraction.
    assign sq_try  = sq_res_reg + sq_bit_reg;
    assign sq_take = (sq_n_reg >= sq_try);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 3; j++) begin
                mn_reg[j] <= '0;
                mx_reg[j] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_index)
                CFG_BOX_MIN_X: mn_reg[0] <= $signed(cfg_data);
                CFG_BOX_MIN_Y: mn_reg[1] <= $signed(cfg_data);
                CFG_BOX_MIN_Z: mn_reg[2] <= $signed(cfg_data);
                CFG_BOX_MAX_X: mx_reg[0] <= $signed(cfg_data);
                CFG_BOX_MAX_Y: mx_reg[1] <= $signed(cfg_data);
                CFG_BOX_MAX_Z: mx_reg[2] <= $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Working registers, updated by command.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                d_reg[0]  <= in_data.dir_x;
                d_reg[1]  <= in_data.dir_y;
                d_reg[2]  <= in_data.dir_z;
                p_reg[0]  <= in_data.pos_x;
                p_reg[1]  <= in_data.pos_y;
                p_reg[2]  <= in_data.pos_z;
                qw_reg    <= clamp_q(in_data.quat_w);
                qx_reg    <= clamp_q(in_data.quat_x);
                qy_reg    <= clamp_q(in_data.quat_y);
                qz_reg    <= clamp_q(in_data.quat_z);
                bias_reg  <= in_data.bias_amount;
            end
            OP_QMUL: begin
                for (int i = 0; i < 3; i++) begin
                    case (cmd.idx[1:0])
                        2'd0:    qp_reg[i]     <= mul_p[i];
                        2'd1:    qp_reg[3 + i] <= mul_p[i];
                        2'd2:    qp_reg[6 + i] <= mul_p[i];
                        default: qp_reg[i]     <= qp_reg[i];
                    endcase
                end
            end
            OP_MAT: begin
                r_reg <= r_next;
            end
            OP_RMUL: begin
                for (int i = 0; i < 3; i++) begin
                    case (rcol)
                        2'd0:    rv_reg[i][0][cmd.idx[0]] <= mul_p[i];
                        2'd1:    rv_reg[i][1][cmd.idx[0]] <= mul_p[i];
                        2'd2:    rv_reg[i][2][cmd.idx[0]] <= mul_p[i];
                        default: rv_reg[i][0][0]          <= rv_reg[i][0][0];
                    endcase
                end
            end
            OP_CPT: begin
                pt_reg <= pt_next;
            end
            OP_DMUL, OP_SQ, OP_BMUL: begin
                dp_reg <= mul_p;
            end
            OP_DCMP: begin
                // Strictly greater wins, so ties keep the earlier corner.
                if (cmd.idx == 5'd0 || dot_next > best_dot_reg) begin
                    best_dot_reg <= dot_next;
                    best_reg     <= pt_reg;
                end
            end
            OP_LSUM: begin
                len2_reg <= $unsigned(dp_reg[0]) + $unsigned(dp_reg[1])
                          + $unsigned(dp_reg[2]);
                k_reg    <= '0;
            end
            OP_NORM: begin
                if (len2_reg[63:56] == 8'd0) begin
                    len2_reg <= len2_reg << 8;
                    k_reg    <= k_reg + 5'd4;
                end else begin
                    len2_reg <= len2_reg << 2;
                    k_reg    <= k_reg + 5'd1;
                end
            end
            OP_SQINIT: begin
                sq_n_reg   <= len2_reg;
                sq_res_reg <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
            end
            OP_SQSTEP: begin
                if (sq_take) begin
                    sq_n_reg   <= sq_n_reg - sq_try;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            OP_DVINIT: begin
                for (int i = 0; i < 3; i++) begin
                    dv_rem_reg[i] <= num_init[i][63:32];
                    dv_num_reg[i] <= num_init[i][31:0];
                    dv_q_reg[i]   <= '0;
                end
            end
            OP_DVSTEP: begin
                for (int i = 0; i < 3; i++) begin
                    if (dv_take[i]) begin
                        dv_rem_reg[i] <= 32'(dv_sh[i] - {1'b0, lroot});
                    end else begin
                        dv_rem_reg[i] <= dv_sh[i][31:0];
                    end
                    dv_q_reg[i]   <= {dv_q_reg[i][30:0], dv_take[i]};
                    dv_num_reg[i] <= {dv_num_reg[i][30:0], 1'b0};
                end
            end
            OP_BADD: begin
                best_reg <= badd_next;
            end
            OP_OUT: begin
                out_reg.support_x <= best_reg[0];
                out_reg.support_y <= best_reg[1];
                out_reg.support_z <= best_reg[2];
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/box_support_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box support point
// Support mapping of a rotated, translated axis-aligned box, with an offset
// along the normalised search direction.
// ----------------------------------------------------------------------------
//  channel  | ports                                    | word
//  ---------+------------------------------------------+-----------------------
//  input    | s_valid, s_ready, s_data                 | direction, pose, bias
//  result   | m_valid, m_ready, m_data                 | support point
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data| one box corner coord
//
// The time a word takes is set by the three shared multiplier lanes, the
// 32-step square root and the 32-step dividers, and is shorter for a zero
// direction. One word is in flight at a time; the next is taken while
// the previous result waits in the output register. A finished word waits in
// its final state while that register is still full. Reset (aresetn low,
// synchronous) clears the box corners to zero and empties the output.
`include "assert_macros.svh"
module box_support_point import bsp_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bsp_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output bsp_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_idx_t    cfg_index,
    input  logic [31:0] cfg_data
);

    bsp_cmd_t  cmd;
    bsp_stat_t stat;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    // Sequencer.
    bsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic and storage.
    bsp_datapath #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_data)
    );

    // Once a word is taken the block is busy for at least the next cycle.
    `BSP_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    // A new result only appears after work in the controller, not straight from idle.
    `BSP_ASSERT(a_result_from_work, aclk, aresetn, $rose(m_valid) |-> $past(!s_ready))
    // The datapath captures a word only on an accepted handshake.
    `BSP_ASSERT_NEVER(a_load_on_accept, aclk, aresetn, (cmd.op == OP_LOAD) && !(s_valid && s_ready))

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box support point testbench
// Drives query words through the box support point block, in most phases under
// random idling on both channels, rewrites the box corners between phases, and checks each
// support point against a fixed-point predictor of the support mapping.
// ----------------------------------------------------------------------------
module testbench;
    import bsp_pkg::*;

    // Support point predictor and store of expected support points.
    class support_board;
        logic signed [31:0] box_lo [3];
        logic signed [31:0] box_hi [3];
        bsp_out_t           pending [$];
        int                 errors;

        function new();
            errors = 0;
            foreach (box_lo[i]) begin
                box_lo[i] = '0;
                box_hi[i] = '0;
            end
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] val);
            case (idx)
                CFG_BOX_MIN_X: box_lo[0] = val;
                CFG_BOX_MIN_Y: box_lo[1] = val;
                CFG_BOX_MIN_Z: box_lo[2] = val;
                CFG_BOX_MAX_X: box_hi[0] = val;
                CFG_BOX_MAX_Y: box_hi[1] = val;
                CFG_BOX_MAX_Z: box_hi[2] = val;
                default: ;
            endcase
        endfunction

        static function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        static function longint rot_entry(longint q60);
            return clip(q60 >>> 30, -(64'sd1 <<< 30), 64'sd1 <<< 30);
        endfunction

        static function longint sat_word(longint v);
            return clip(v, -64'sd2147483648, 64'sd2147483647);
        endfunction

        // Floor square root of a 64-bit unsigned value, bit by bit.
        static function longint unsigned root64(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // Works out the support point of one query and queues it.
        function void note_query(bsp_in_t q);
            longint d[3], p[3], rm[3][3], best[3], v[3], pt[3];
            longint w, x, y, z, bias, dot, bestdot, acc, n;
            longint unsigned len2, lroot, m;
            logic [2:0] sel;
            int k;
            bsp_out_t r;
            d[0] = q.dir_x; d[1] = q.dir_y; d[2] = q.dir_z;
            p[0] = q.pos_x; p[1] = q.pos_y; p[2] = q.pos_z;
            w = clip(q.quat_w, -(64'sd1 <<< 30), 64'sd1 <<< 30);
            x = clip(q.quat_x, -(64'sd1 <<< 30), 64'sd1 <<< 30);
            y = clip(q.quat_y, -(64'sd1 <<< 30), 64'sd1 <<< 30);
            z = clip(q.quat_z, -(64'sd1 <<< 30), 64'sd1 <<< 30);
            bias = q.bias_amount;
            rm[0][0] = rot_entry((64'sd1 <<< 60) - 2 * (y * y + z * z));
            rm[0][1] = rot_entry(2 * (x * y - w * z));
            rm[0][2] = rot_entry(2 * (x * z + w * y));
            rm[1][0] = rot_entry(2 * (x * y + w * z));
            rm[1][1] = rot_entry((64'sd1 <<< 60) - 2 * (x * x + z * z));
            rm[1][2] = rot_entry(2 * (y * z - w * x));
            rm[2][0] = rot_entry(2 * (x * z - w * y));
            rm[2][1] = rot_entry(2 * (y * z + w * x));
            rm[2][2] = rot_entry((64'sd1 <<< 60) - 2 * (x * x + y * y));
            bestdot = 0;
            for (int c = 0; c < 8; c++) begin
                case (c)
                    0: sel = 3'd0; 1: sel = 3'd1; 2: sel = 3'd2; 3: sel = 3'd4;
                    4: sel = 3'd7; 5: sel = 3'd6; 6: sel = 3'd5; default: sel = 3'd3;
                endcase
                for (int i = 0; i < 3; i++) v[i] = sel[i] ? box_hi[i] : box_lo[i];
                dot = 0;
                for (int i = 0; i < 3; i++) begin
                    acc = rm[i][0] * v[0] + rm[i][1] * v[1] + rm[i][2] * v[2];
                    pt[i] = sat_word((acc >>> 30) + p[i]);
                    dot += (pt[i] * d[i]) >>> 16;
                end
                // Ties keep the earlier corner.
                if (c == 0 || dot > bestdot) begin
                    bestdot = dot;
                    best = pt;
                end
            end
            len2 = 0;
            for (int i = 0; i < 3; i++) begin
                m = d[i] < 0 ? -d[i] : d[i];
                len2 += m * m;
            end
            // A zero direction adds no bias.
            if (len2 != 0) begin
                k = 0;
                while ((len2 >> 62) == 0) begin
                    len2 <<= 2;
                    k++;
                end
                lroot = root64(len2);
                for (int i = 0; i < 3; i++) begin
                    m = d[i] < 0 ? -d[i] : d[i];
                    n = ((m << k) << 30) / lroot;
                    if (d[i] < 0) n = -n;
                    best[i] = sat_word(best[i] + ((n * bias) >>> 30));
                end
            end
            r.support_x = 32'(best[0]);
            r.support_y = 32'(best[1]);
            r.support_z = 32'(best[2]);
            pending.push_back(r);
        endfunction

        function void check_point(bsp_out_t got);
            bsp_out_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected support point %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.support_x !== want.support_x) begin
                $display("%0t: support_x expected %h actual %h", $time,
                         want.support_x, got.support_x);
                errors++;
            end
            if (got.support_y !== want.support_y) begin
                $display("%0t: support_y expected %h actual %h", $time,
                         want.support_y, got.support_y);
                errors++;
            end
            if (got.support_z !== want.support_z) begin
                $display("%0t: support_z expected %h actual %h", $time,
                         want.support_z, got.support_z);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    bsp_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    bsp_out_t    m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [31:0] cfg_data;

    support_board board;
    bit           idle_on;
    int           hold_cycles;

    box_support_point u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    // Random 32-bit value leaning towards the extremes.
    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            3: return $signed($urandom_range(0, 400000)) - 200000;
            default: return $urandom;
        endcase
    endfunction

    // Quaternion component: mostly in range, now and then far outside it.
    function automatic logic [31:0] any_quat();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'sd1073741824;
            2: return -32'sd1073741824;
            default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sd1073741824;
        endcase
    endfunction

    // Roughly unit quaternion from a few well-known rotations, or the pose unchanged.
    function automatic bsp_in_t unit_pose(bsp_in_t q);
        case ($urandom_range(0, 3))
            0: begin q.quat_w = 32'sd1073741824; q.quat_x = 0; q.quat_y = 0; q.quat_z = 0; end
            1: begin q.quat_w = 32'sd759250125; q.quat_x = 0; q.quat_y = 0;
                     q.quat_z = 32'sd759250125; end
            2: begin q.quat_w = 32'sd536870912; q.quat_x = 32'sd536870912;
                     q.quat_y = -32'sd536870912; q.quat_z = 32'sd536870912; end
            default: ;
        endcase
        return q;
    endfunction

    // Offers one register write and holds it until taken; the caller drops valid.
    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_reg(idx, val);
    endtask

    task automatic load_box(logic [31:0] lo_x, logic [31:0] lo_y, logic [31:0] lo_z,
                            logic [31:0] hi_x, logic [31:0] hi_y, logic [31:0] hi_z);
        write_reg(CFG_BOX_MIN_X, lo_x);
        write_reg(CFG_BOX_MIN_Y, lo_y);
        write_reg(CFG_BOX_MIN_Z, lo_z);
        write_reg(CFG_BOX_MAX_X, hi_x);
        write_reg(CFG_BOX_MAX_Y, hi_y);
        write_reg(CFG_BOX_MAX_Z, hi_z);
        cfg_valid <= 1'b0;
    endtask

    // Offers one word and holds it until taken, after an optional idle burst.
    task automatic send_query(bsp_in_t q);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= q;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_query(q);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic bsp_in_t random_query();
        bsp_in_t q;
        q.dir_x = any_word(); q.dir_y = any_word(); q.dir_z = any_word();
        q.pos_x = any_word(); q.pos_y = any_word(); q.pos_z = any_word();
        q.quat_w = any_quat(); q.quat_x = any_quat();
        q.quat_y = any_quat(); q.quat_z = any_quat();
        q.bias_amount = any_word();
        if ($urandom_range(0, 9) == 0) begin
            q.dir_x = 0; q.dir_y = 0; q.dir_z = 0;
        end
        if ($urandom_range(0, 1)) q = unit_pose(q);
        return q;
    endfunction

    task automatic random_box();
        load_box(any_word(), any_word(), any_word(), any_word(), any_word(), any_word());
    endtask

    // Result side: accepts and checks words, stalling in bursts or on request.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_point(m_data);
    end

    initial begin
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        bsp_in_t q;
        board       = new();
        idle_on     = 1'b1;
        hold_cycles = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BOX_MIN_X;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: unit box, extremes of direction, pose and bias.
        load_box(-32'sd65536, -32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536);
        q = '0;
        q.quat_w = 32'sd1073741824;
        send_query(q);                                     // zero direction
        q.dir_x = 32'sd65536; q.bias_amount = 32'sd65536;
        send_query(q);
        q.dir_x = 32'h7FFF_FFFF; q.dir_y = 32'h8000_0000; q.dir_z = 32'h7FFF_FFFF;
        q.bias_amount = 32'h8000_0000;
        send_query(q);
        q.pos_x = 32'h7FFF_FFFF; q.pos_y = 32'h8000_0000; q.bias_amount = 32'h7FFF_FFFF;
        send_query(q);
        q = '0;
        q.dir_y = 32'sd65536; q.dir_z = 32'sd65536;       // tie between corners
        q.quat_w = 32'sd1073741824;
        send_query(q);
        q.quat_w = 32'h7FFF_FFFF; q.quat_x = 32'h8000_0000;
        q.quat_y = 32'h7FFF_FFFF; q.quat_z = 32'h8000_0000; // out of range, clamped
        send_query(q);
        q.quat_w = 32'sd1; q.quat_x = 32'sd1; q.quat_y = 0; q.quat_z = 0;
        send_query(q);
        for (int i = 0; i < 8; i++) send_query(random_query());
        stop_sending();
        drain();

        // Extreme box, min above max.
        load_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        for (int i = 0; i < 8; i++) send_query(random_query());

        // Long receiver hold while the sender keeps offering.
        hold_cycles = 600;
        for (int i = 0; i < 6; i++) send_query(random_query());
        stop_sending();
        drain();

        // Random phases under several boxes.
        for (int ph = 0; ph < 6; ph++) begin
            random_box();
            for (int i = 0; i < 100; i++) send_query(random_query());
            stop_sending();
            drain();
        end

        // Last stretch with no idling.
        idle_on = 1'b0;
        load_box(0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 50; i++) send_query(random_query());
        stop_sending();
        drain();

        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/bsp_pkg.sv
rtl/bsp_ctrl.sv
rtl/bsp_datapath.sv
rtl/box_support_point.sv
verif/testbench.sv
